>>> hw/rtl/crcc_pkg.sv
package crcc_pkg;

    // Coordinate width: 16-bit position plus a 15-bit size fits in 17 signed bits
    localparam int COORD_W = 17;
    localparam int SIZE_W  = 15;
    localparam int POS_W   = 16;
    localparam int MAG_W   = 17;              // |center - edge| magnitude
    localparam int WSQ_W   = 2 * SIZE_W;      // diameter squared
    localparam int SQ_W    = 2 * MAG_W;       // one squared distance term
    localparam int KIND_W  = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE         = 4'd0,
        KIND_LEFT         = 4'd1,
        KIND_TOP          = 4'd2,
        KIND_RIGHT        = 4'd3,
        KIND_BOTTOM       = 4'd4,
        KIND_TOP_LEFT     = 4'd5,
        KIND_TOP_RIGHT    = 4'd6,
        KIND_BOTTOM_LEFT  = 4'd7,
        KIND_BOTTOM_RIGHT = 4'd8
    } kind_t;

    // Stage 1: edges and center
    typedef struct packed {
        logic               valid;
        logic               nonempty;
        coord_t             ax;
        coord_t             ay;
        coord_t             ax1;
        coord_t             ay1;
        coord_t             bx;
        coord_t             by;
        coord_t             bx1;
        coord_t             by1;
        coord_t             cx;
        coord_t             cy;
        logic [SIZE_W-1:0]  aw;
    } prep_t;

    // Side decisions and contact candidates, carried to the output stage
    typedef struct packed {
        logic   ovl;
        logic   in_x;
        logic   in_y;
        logic   bottom;
        logic   right;
        coord_t cx;
        coord_t cy;
        coord_t bx;
        coord_t by;
        coord_t bx1;
        coord_t by1;
    } side_t;

    // Stage 2: side tests, distance magnitudes, diameter squared
    typedef struct packed {
        logic              valid;
        side_t             side;
        logic [MAG_W-1:0]  adx0;
        logic [MAG_W-1:0]  adx1;
        logic [MAG_W-1:0]  ady0;
        logic [MAG_W-1:0]  ady1;
        logic [WSQ_W-1:0]  wsq;
    } geom_t;

    // Stage 4: corner tests resolved
    typedef struct packed {
        logic  valid;
        side_t side;
        logic  tl;
        logic  tr;
        logic  bl;
        logic  br;
    } corner_t;

endpackage

>>> hw/rtl/crcc_prep.sv
module crcc_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [crcc_pkg::POS_W-1:0]    circle_x,
    input  logic signed [crcc_pkg::POS_W-1:0]    circle_y,
    input  logic        [crcc_pkg::SIZE_W-1:0]   circle_width,
    input  logic        [crcc_pkg::SIZE_W-1:0]   circle_height,
    input  logic signed [crcc_pkg::POS_W-1:0]    rect_x,
    input  logic signed [crcc_pkg::POS_W-1:0]    rect_y,
    input  logic        [crcc_pkg::SIZE_W-1:0]   rect_width,
    input  logic        [crcc_pkg::SIZE_W-1:0]   rect_height,
    output crcc_pkg::prep_t                      prep
);
    import crcc_pkg::*;

    prep_t prep_reg;
    prep_t prep_next;

    // Edges, center (floor of half size) and empty-box check
    always_comb
    begin
        prep_next.valid    = start;
        prep_next.nonempty = (circle_width != '0) && (circle_height != '0) &&
                             (rect_width != '0) && (rect_height != '0);
        prep_next.ax  = COORD_W'(circle_x);
        prep_next.ay  = COORD_W'(circle_y);
        prep_next.bx  = COORD_W'(rect_x);
        prep_next.by  = COORD_W'(rect_y);
        prep_next.ax1 = COORD_W'(circle_x) + coord_t'({2'b00, circle_width});
        prep_next.ay1 = COORD_W'(circle_y) + coord_t'({2'b00, circle_height});
        prep_next.bx1 = COORD_W'(rect_x) + coord_t'({2'b00, rect_width});
        prep_next.by1 = COORD_W'(rect_y) + coord_t'({2'b00, rect_height});
        prep_next.cx  = COORD_W'(circle_x) + coord_t'({3'b000, circle_width[SIZE_W-1:1]});
        prep_next.cy  = COORD_W'(circle_y) + coord_t'({3'b000, circle_height[SIZE_W-1:1]});
        prep_next.aw  = circle_width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= '0;
        end
        else
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

>>> hw/rtl/crcc_geom.sv
module crcc_geom (
    input  logic              clk,
    input  logic              rst_n,
    input  crcc_pkg::prep_t   prep,
    output crcc_pkg::geom_t   geom
);
    import crcc_pkg::*;

    geom_t geom_reg;
    geom_t geom_next;

    logic signed [COORD_W:0] ddx0;
    logic signed [COORD_W:0] ddx1;
    logic signed [COORD_W:0] ddy0;
    logic signed [COORD_W:0] ddy1;

    function automatic logic [MAG_W-1:0] mag(input logic signed [COORD_W:0] d);
        logic signed [COORD_W:0] n;
        n = -d;
        return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // Signed center-to-edge offsets, one extra bit of headroom
    always_comb
    begin
        ddx0 = (COORD_W+1)'(prep.cx) - (COORD_W+1)'(prep.bx);
        ddx1 = (COORD_W+1)'(prep.cx) - (COORD_W+1)'(prep.bx1);
        ddy0 = (COORD_W+1)'(prep.cy) - (COORD_W+1)'(prep.by);
        ddy1 = (COORD_W+1)'(prep.cy) - (COORD_W+1)'(prep.by1);
    end

    // Overlap and side tests, offset magnitudes, diameter squared
    always_comb
    begin
        geom_next.valid       = prep.valid;
        geom_next.side.ovl    = prep.nonempty &&
                                (prep.ax1 > prep.bx) && (prep.bx1 > prep.ax) &&
                                (prep.ay1 > prep.by) && (prep.by1 > prep.ay);
        geom_next.side.in_x   = (prep.bx <= prep.cx) && (prep.cx <= prep.bx1);
        geom_next.side.in_y   = (prep.by <= prep.cy) && (prep.cy <= prep.by1);
        geom_next.side.bottom = (prep.ay1 <= prep.by1);
        geom_next.side.right  = (prep.ax1 <= prep.bx1);
        geom_next.side.cx     = prep.cx;
        geom_next.side.cy     = prep.cy;
        geom_next.side.bx     = prep.bx;
        geom_next.side.by     = prep.by;
        geom_next.side.bx1    = prep.bx1;
        geom_next.side.by1    = prep.by1;
        geom_next.adx0        = mag(ddx0);
        geom_next.adx1        = mag(ddx1);
        geom_next.ady0        = mag(ddy0);
        geom_next.ady1        = mag(ddy1);
        geom_next.wsq         = {{SIZE_W{1'b0}}, prep.aw} * {{SIZE_W{1'b0}}, prep.aw};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= '0;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

>>> hw/rtl/crcc_dist.sv
module crcc_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  crcc_pkg::geom_t   geom,
    output crcc_pkg::corner_t corner
);
    import crcc_pkg::*;

    localparam int CMP_W = SQ_W + 3;   // 4 * (a^2 + b^2)

    typedef struct packed {
        logic              valid;
        side_t             side;
        logic [SQ_W-1:0]   sdx0;
        logic [SQ_W-1:0]   sdx1;
        logic [SQ_W-1:0]   sdy0;
        logic [SQ_W-1:0]   sdy1;
        logic [WSQ_W-1:0]  wsq;
    } sq_t;

    sq_t     sq_reg;
    sq_t     sq_next;
    corner_t corner_reg;
    corner_t corner_next;

    logic [SQ_W:0]      sum_tl;
    logic [SQ_W:0]      sum_tr;
    logic [SQ_W:0]      sum_bl;
    logic [SQ_W:0]      sum_br;
    logic [CMP_W-1:0]   lim;

    // Stage 3: squared offsets
    always_comb
    begin
        sq_next.valid = geom.valid;
        sq_next.side  = geom.side;
        sq_next.sdx0  = {{MAG_W{1'b0}}, geom.adx0} * {{MAG_W{1'b0}}, geom.adx0};
        sq_next.sdx1  = {{MAG_W{1'b0}}, geom.adx1} * {{MAG_W{1'b0}}, geom.adx1};
        sq_next.sdy0  = {{MAG_W{1'b0}}, geom.ady0} * {{MAG_W{1'b0}}, geom.ady0};
        sq_next.sdy1  = {{MAG_W{1'b0}}, geom.ady1} * {{MAG_W{1'b0}}, geom.ady1};
        sq_next.wsq   = geom.wsq;
    end

    // Stage 4: corner distance compares, 4*(dx^2+dy^2) <= w^2
    always_comb
    begin
        sum_tl = {1'b0, sq_reg.sdx0} + {1'b0, sq_reg.sdy0};
        sum_tr = {1'b0, sq_reg.sdx1} + {1'b0, sq_reg.sdy0};
        sum_bl = {1'b0, sq_reg.sdx0} + {1'b0, sq_reg.sdy1};
        sum_br = {1'b0, sq_reg.sdx1} + {1'b0, sq_reg.sdy1};
        lim    = {{(CMP_W-WSQ_W){1'b0}}, sq_reg.wsq};

        corner_next.valid = sq_reg.valid;
        corner_next.side  = sq_reg.side;
        corner_next.tl    = ({sum_tl, 2'b00} <= lim);
        corner_next.tr    = ({sum_tr, 2'b00} <= lim);
        corner_next.bl    = ({sum_bl, 2'b00} <= lim);
        corner_next.br    = ({sum_br, 2'b00} <= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg     <= '0;
            corner_reg <= '0;
        end
        else
        begin
            sq_reg     <= sq_next;
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

>>> hw/rtl/crcc_select.sv
module crcc_select (
    input  logic                              clk,
    input  logic                              rst_n,
    input  crcc_pkg::corner_t                 corner,
    output logic                              done,
    output logic                              hit,
    output logic [crcc_pkg::KIND_W-1:0]       contact_kind,
    output logic signed [crcc_pkg::COORD_W-1:0] contact_x,
    output logic signed [crcc_pkg::COORD_W-1:0] contact_y
);
    import crcc_pkg::*;

    logic   done_reg;
    logic   hit_reg;
    kind_t  kind_reg;
    kind_t  kind_next;
    coord_t x_reg;
    coord_t x_next;
    coord_t y_reg;
    coord_t y_next;

    // Priority: top/bottom first, then left/right, then corners TL, TR, BL, BR
    always_comb
    begin
        kind_next = KIND_NONE;
        x_next    = '0;
        y_next    = '0;
        if (corner.side.ovl)
        begin
            priority if (corner.side.in_x)
            begin
                x_next = corner.side.cx;
                if (corner.side.bottom)
                begin
                    kind_next = KIND_BOTTOM;
                    y_next    = corner.side.by;
                end
                else
                begin
                    kind_next = KIND_TOP;
                    y_next    = corner.side.by1;
                end
            end
            else if (corner.side.in_y)
            begin
                y_next = corner.side.cy;
                if (corner.side.right)
                begin
                    kind_next = KIND_RIGHT;
                    x_next    = corner.side.bx;
                end
                else
                begin
                    kind_next = KIND_LEFT;
                    x_next    = corner.side.bx1;
                end
            end
            else if (corner.tl)
            begin
                kind_next = KIND_TOP_LEFT;
                x_next    = corner.side.bx;
                y_next    = corner.side.by;
            end
            else if (corner.tr)
            begin
                kind_next = KIND_TOP_RIGHT;
                x_next    = corner.side.bx1;
                y_next    = corner.side.by;
            end
            else if (corner.bl)
            begin
                kind_next = KIND_BOTTOM_LEFT;
                x_next    = corner.side.bx;
                y_next    = corner.side.by1;
            end
            else if (corner.br)
            begin
                kind_next = KIND_BOTTOM_RIGHT;
                x_next    = corner.side.bx1;
                y_next    = corner.side.by1;
            end
            else
            begin
                kind_next = KIND_NONE;
            end
        end
    end

    // Stage 5: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
            kind_reg <= KIND_NONE;
            x_reg    <= '0;
            y_reg    <= '0;
        end
        else
        begin
            done_reg <= corner.valid;
            hit_reg  <= (kind_next != KIND_NONE);
            kind_reg <= kind_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign contact_kind = kind_reg;
    assign contact_x    = x_reg;
    assign contact_y    = y_reg;

endmodule

>>> hw/rtl/circle_rect_contact_classifier.sv
// Circle vs. axis-aligned rectangle contact classifier.
// A transaction is accepted when start is high and busy low; done marks its result.
// Throughput: one transaction per cycle; five register stages (edges, side tests,
// squaring multipliers, corner compares, output select). busy is always low.
// Reset (rst_n, asynchronous, active low) drops every stage valid; no transaction
// in flight survives it. done is a one-cycle strobe; the receiver cannot stall.
module circle_rect_contact_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [crcc_pkg::POS_W-1:0]    circle_x,
    input  logic signed [crcc_pkg::POS_W-1:0]    circle_y,
    input  logic        [crcc_pkg::SIZE_W-1:0]   circle_width,
    input  logic        [crcc_pkg::SIZE_W-1:0]   circle_height,
    input  logic signed [crcc_pkg::POS_W-1:0]    rect_x,
    input  logic signed [crcc_pkg::POS_W-1:0]    rect_y,
    input  logic        [crcc_pkg::SIZE_W-1:0]   rect_width,
    input  logic        [crcc_pkg::SIZE_W-1:0]   rect_height,
    output logic                                 done,
    output logic                                 hit,
    output logic        [crcc_pkg::KIND_W-1:0]   contact_kind,
    output logic signed [crcc_pkg::COORD_W-1:0]  contact_x,
    output logic signed [crcc_pkg::COORD_W-1:0]  contact_y
);
    import crcc_pkg::*;

    prep_t   prep;
    geom_t   geom;
    corner_t corner;

    // Fully pipelined, never stalls
    assign busy = 1'b0;

    crcc_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start && !busy),
        .circle_x      (circle_x),
        .circle_y      (circle_y),
        .circle_width  (circle_width),
        .circle_height (circle_height),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .prep          (prep)
    );

    crcc_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .prep  (prep),
        .geom  (geom)
    );

    crcc_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .geom   (geom),
        .corner (corner)
    );

    crcc_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner       (corner),
        .done         (done),
        .hit          (hit),
        .contact_kind (contact_kind),
        .contact_x    (contact_x),
        .contact_y    (contact_y)
    );

endmodule

>>> hw/rtl/crcc_checker.sv
module crcc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic signed [crcc_pkg::POS_W-1:0]    rect_y,
    input logic                                 done,
    input logic                                 hit,
    input logic        [crcc_pkg::KIND_W-1:0]   contact_kind,
    input logic signed [crcc_pkg::COORD_W-1:0]  contact_x,
    input logic signed [crcc_pkg::COORD_W-1:0]  contact_y
);
    import crcc_pkg::*;

    // Every accepted transaction yields exactly one result
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted transaction produced no result");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without an accepted transaction");

    // A miss reports kind none and a zero contact point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (contact_kind == KIND_NONE && contact_x == '0 &&
                            contact_y == '0))
        else $error("miss with nonzero kind or point");

    // A hit carries a defined kind
    a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (contact_kind != KIND_NONE && contact_kind <= KIND_BOTTOM_RIGHT))
        else $error("hit with invalid contact kind");

    // Bottom contact sits on the rectangle top edge
    a_bottom_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && contact_kind == KIND_BOTTOM) |->
            (contact_y == COORD_W'($past(rect_y, 5))))
        else $error("bottom contact y does not match rectangle top");

endmodule

bind circle_rect_contact_classifier crcc_checker u_crcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .rect_y       (rect_y),
    .done         (done),
    .hit          (hit),
    .contact_kind (contact_kind),
    .contact_x    (contact_x),
    .contact_y    (contact_y)
);
